// ===== rtl/cstok_pkg.sv =====
// Shared constants, result types and character-class functions for the
// character stream tokenizer. No dependencies; every other file uses it.
`default_nettype none

package cstok_pkg;

    // Counter widths.
    localparam int POS_WIDTH  = 16;
    localparam int LINE_WIDTH = 16;

    // Result queue geometry.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Token kinds.
    localparam logic [4:0] KIND_EOF       = 5'd0;
    localparam logic [4:0] KIND_ILLEGAL   = 5'd1;
    localparam logic [4:0] KIND_PLUS      = 5'd2;
    localparam logic [4:0] KIND_MINUS     = 5'd3;
    localparam logic [4:0] KIND_ASTERISK  = 5'd4;
    localparam logic [4:0] KIND_SLASH     = 5'd5;
    localparam logic [4:0] KIND_ASSIGN    = 5'd6;
    localparam logic [4:0] KIND_BANG      = 5'd7;
    localparam logic [4:0] KIND_EQ        = 5'd8;
    localparam logic [4:0] KIND_NEQ       = 5'd9;
    localparam logic [4:0] KIND_LT        = 5'd10;
    localparam logic [4:0] KIND_GT        = 5'd11;
    localparam logic [4:0] KIND_LTE       = 5'd12;
    localparam logic [4:0] KIND_GTE       = 5'd13;
    localparam logic [4:0] KIND_LOR       = 5'd14;
    localparam logic [4:0] KIND_LAND      = 5'd15;
    localparam logic [4:0] KIND_LPAREN    = 5'd16;
    localparam logic [4:0] KIND_RPAREN    = 5'd17;
    localparam logic [4:0] KIND_LBRACE    = 5'd18;
    localparam logic [4:0] KIND_RBRACE    = 5'd19;
    localparam logic [4:0] KIND_LBRACKET  = 5'd20;
    localparam logic [4:0] KIND_RBRACKET  = 5'd21;
    localparam logic [4:0] KIND_SEMICOLON = 5'd22;
    localparam logic [4:0] KIND_COLON     = 5'd23;
    localparam logic [4:0] KIND_COMMA     = 5'd24;
    localparam logic [4:0] KIND_PERIOD    = 5'd25;
    localparam logic [4:0] KIND_INT       = 5'd26;
    localparam logic [4:0] KIND_FLOAT     = 5'd27;
    localparam logic [4:0] KIND_STRING    = 5'd28;

    // Lookup result meaning "no operator here"; shares the EOF code.
    localparam logic [4:0] KIND_NONE = 5'd0;

    // Input request codes.
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Characters with special meaning.
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    // One result as it travels through the queue and out of the block.
    typedef struct packed {
        logic [4:0]            kind;
        logic [POS_WIDTH-1:0]  position;
        logic [LINE_WIDTH-1:0] line;
        logic [LINE_WIDTH-1:0] column;
        logic [POS_WIDTH-1:0]  length;
        logic                  last;
    } token_t;

    // Results of one processed request, handed from the scanner to the queue.
    typedef struct packed {
        logic [1:0] count;
        token_t     first;
        token_t     second;
    } push_t;

    // Saturating increments.
    function automatic logic [POS_WIDTH-1:0] inc_pos(input logic [POS_WIDTH-1:0] v);
        return (&v) ? v : v + POS_WIDTH'(1);
    endfunction

    function automatic logic [LINE_WIDTH-1:0] inc_line(input logic [LINE_WIDTH-1:0] v);
        return (&v) ? v : v + LINE_WIDTH'(1);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    // Characters that wait one character for a possible second half.
    function automatic logic is_pend_char(input logic [7:0] c);
        return c inside {CH_BANG, CH_EQ, CH_LT, CH_GT, CH_PIPE, CH_AMP};
    endfunction

    // Operators and punctuation that always stand alone.
    function automatic logic [4:0] single_kind(input logic [7:0] c);
        case (c)
            8'h2B:   return KIND_PLUS;
            8'h2D:   return KIND_MINUS;
            8'h2A:   return KIND_ASTERISK;
            8'h2F:   return KIND_SLASH;
            8'h28:   return KIND_LPAREN;
            8'h29:   return KIND_RPAREN;
            8'h7B:   return KIND_LBRACE;
            8'h7D:   return KIND_RBRACE;
            8'h5B:   return KIND_LBRACKET;
            8'h5D:   return KIND_RBRACKET;
            8'h3B:   return KIND_SEMICOLON;
            8'h3A:   return KIND_COLON;
            8'h2C:   return KIND_COMMA;
            CH_DOT:  return KIND_PERIOD;
            default: return KIND_NONE;
        endcase
    endfunction

    // Kind of a pending character that found no partner.
    function automatic logic [4:0] pend_alone(input logic [7:0] c);
        case (c)
            CH_EQ:   return KIND_ASSIGN;
            CH_BANG: return KIND_BANG;
            CH_LT:   return KIND_LT;
            CH_GT:   return KIND_GT;
            default: return KIND_ILLEGAL;
        endcase
    endfunction

    // Kind of a two-character operator, or KIND_NONE when there is none.
    function automatic logic [4:0] pend_pair(input logic [7:0] first, input logic [7:0] c);
        if (first == CH_PIPE) begin
            return (c == CH_PIPE) ? KIND_LOR : KIND_NONE;
        end
        if (first == CH_AMP) begin
            return (c == CH_AMP) ? KIND_LAND : KIND_NONE;
        end
        if (c != CH_EQ) begin
            return KIND_NONE;
        end
        case (first)
            CH_EQ:   return KIND_EQ;
            CH_BANG: return KIND_NEQ;
            CH_LT:   return KIND_LTE;
            CH_GT:   return KIND_GTE;
            default: return KIND_NONE;
        endcase
    endfunction

    // Number kind from the saturating dot count.
    function automatic logic [4:0] number_kind(input logic [1:0] dots);
        case (dots)
            2'd0:    return KIND_INT;
            2'd1:    return KIND_FLOAT;
            default: return KIND_ILLEGAL;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/cstok_ifs.sv =====
// Valid/ready channel interfaces for character requests and token results.
// Depends on cstok_pkg for the counter widths.
`default_nettype none

interface cstok_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_code;

    modport source (output valid, output op, output char_code, input ready);
    modport sink   (input valid, input op, input char_code, output ready);
endinterface

interface cstok_out_if;
    logic                            valid;
    logic                            ready;
    logic [4:0]                      token_class;
    logic [cstok_pkg::POS_WIDTH-1:0]  start_position;
    logic [cstok_pkg::LINE_WIDTH-1:0] start_line;
    logic [cstok_pkg::LINE_WIDTH-1:0] start_column;
    logic [cstok_pkg::POS_WIDTH-1:0]  literal_length;
    logic                            last_of_run;

    modport source (output valid, output token_class, output start_position,
                    output start_line, output start_column, output literal_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_class, input start_position,
                    input start_line, input start_column, input literal_length,
                    input last_of_run, output ready);
    modport monitor (input valid, input ready, input token_class, input start_position,
                     input start_line, input start_column, input literal_length,
                     input last_of_run);
endinterface

`default_nettype wire

// ===== rtl/cstok_scan.sv =====
// Input register, scanner state and the combinational lexing step.
// Depends on cstok_pkg and the cstok_in_if interface.
`default_nettype none

module cstok_scan (
    input  logic             clk,
    input  logic             rst_n,
    cstok_in_if.sink         char_in,
    input  logic             room,
    output cstok_pkg::push_t push
);

    // Scan modes.
    localparam logic [2:0] MODE_IDLE = 3'd0;
    localparam logic [2:0] MODE_PEND = 3'd1;
    localparam logic [2:0] MODE_NUM  = 3'd2;
    localparam logic [2:0] MODE_STR  = 3'd3;

    localparam int PW = cstok_pkg::POS_WIDTH;
    localparam int LW = cstok_pkg::LINE_WIDTH;

    // Input register.
    logic       in_valid_reg;
    logic       in_op_reg;
    logic [7:0] in_char_reg;

    // Scanner state.
    logic [2:0]    mode_reg,     mode_next;
    logic [7:0]    pending_reg,  pending_next;
    logic          esc_reg,      esc_next;
    logic          cr_reg,       cr_next;
    logic [1:0]    dot_reg,      dot_next;
    logic [PW-1:0] pos_reg,      pos_next;
    logic [LW-1:0] line_reg,     line_next;
    logic [LW-1:0] col_reg,      col_next;
    logic [PW-1:0] spos_reg,     spos_next;
    logic [LW-1:0] sline_reg,    sline_next;
    logic [LW-1:0] scol_reg,     scol_next;
    logic [PW-1:0] len_reg,      len_next;

    // Slot A carries the token that was being built, slot B a fresh one.
    logic             a_valid;
    logic             b_valid;
    cstok_pkg::token_t tok_a;
    cstok_pkg::token_t tok_b;
    logic             do_idle;
    logic [LW-1:0]    col_inc;
    logic [4:0]       pair_kind;
    logic [7:0]       c;
    logic             fire;

    assign c    = in_char_reg;
    assign fire = in_valid_reg && room;

    // The input register takes a request when it is empty or empties in the same cycle.
    assign char_in.ready = !in_valid_reg || room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (char_in.ready)
        begin
            in_valid_reg <= char_in.valid;
        end
    end

    // Request payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (char_in.valid && char_in.ready)
        begin
            in_op_reg   <= char_in.op;
            in_char_reg <= char_in.char_code;
        end
    end

    // One lexing step for the request held in the input register.
    always_comb
    begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        esc_next     = esc_reg;
        cr_next      = cr_reg;
        dot_next     = dot_reg;
        pos_next     = pos_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        spos_next    = spos_reg;
        sline_next   = sline_reg;
        scol_next    = scol_reg;
        len_next     = len_reg;

        a_valid       = 1'b0;
        tok_a.kind    = cstok_pkg::KIND_EOF;
        tok_a.position = spos_reg;
        tok_a.line    = sline_reg;
        tok_a.column  = scol_reg;
        tok_a.length  = len_reg;
        tok_a.last    = 1'b0;

        b_valid       = 1'b0;
        tok_b.kind    = cstok_pkg::KIND_EOF;
        tok_b.position = pos_reg;
        tok_b.line    = line_reg;
        tok_b.column  = col_reg;
        tok_b.length  = '0;
        tok_b.last    = 1'b1;

        do_idle   = 1'b0;
        col_inc   = cstok_pkg::inc_line(col_reg);
        pair_kind = cstok_pkg::pend_pair(pending_reg, c);

        if (in_op_reg == cstok_pkg::OP_END)
        begin
            // Flush any open token, then report end of input and start over.
            case (mode_reg)
                MODE_PEND:
                begin
                    a_valid      = 1'b1;
                    tok_a.kind   = cstok_pkg::pend_alone(pending_reg);
                    tok_a.length = PW'(1);
                end
                MODE_NUM:
                begin
                    a_valid    = 1'b1;
                    tok_a.kind = cstok_pkg::number_kind(dot_reg);
                end
                MODE_STR:
                begin
                    a_valid    = 1'b1;
                    tok_a.kind = cstok_pkg::KIND_STRING;
                end
                default:
                begin
                end
            endcase
            b_valid      = 1'b1;
            mode_next    = MODE_IDLE;
            pending_next = '0;
            esc_next     = 1'b0;
            cr_next      = 1'b0;
            dot_next     = '0;
            pos_next     = '0;
            line_next    = LW'(1);
            col_next     = '0;
            spos_next    = '0;
            sline_next   = LW'(1);
            scol_next    = '0;
            len_next     = '0;
        end
        else
        begin
            pos_next = cstok_pkg::inc_pos(pos_reg);
            if (cr_reg && (c == cstok_pkg::CH_LF))
            begin
                // The LF of a CR LF pair is no character of its own.
                cr_next = 1'b0;
                if (mode_reg == MODE_STR)
                begin
                    len_next = cstok_pkg::inc_pos(len_reg);
                end
            end
            else
            begin
                // Location of this character, used by a token it starts.
                tok_b.position = pos_reg;
                tok_b.line     = line_reg;
                tok_b.column   = col_inc;
                tok_b.length   = PW'(1);
                if ((c == cstok_pkg::CH_LF) || (c == cstok_pkg::CH_CR))
                begin
                    line_next = cstok_pkg::inc_line(line_reg);
                    col_next  = '0;
                end
                else
                begin
                    col_next = col_inc;
                end
                cr_next = (c == cstok_pkg::CH_CR);

                case (mode_reg)
                    MODE_PEND:
                    begin
                        mode_next = MODE_IDLE;
                        a_valid   = 1'b1;
                        if (pair_kind != cstok_pkg::KIND_NONE)
                        begin
                            tok_a.kind   = pair_kind;
                            tok_a.length = PW'(2);
                            len_next     = PW'(2);
                        end
                        else
                        begin
                            tok_a.kind   = cstok_pkg::pend_alone(pending_reg);
                            tok_a.length = PW'(1);
                            len_next     = PW'(1);
                            do_idle      = 1'b1;
                        end
                    end
                    MODE_NUM:
                    begin
                        if (cstok_pkg::is_digit(c) || (c == cstok_pkg::CH_DOT))
                        begin
                            len_next = cstok_pkg::inc_pos(len_reg);
                            if ((c == cstok_pkg::CH_DOT) && (dot_reg < 2'd2))
                            begin
                                dot_next = dot_reg + 2'd1;
                            end
                        end
                        else
                        begin
                            mode_next  = MODE_IDLE;
                            a_valid    = 1'b1;
                            tok_a.kind = cstok_pkg::number_kind(dot_reg);
                            do_idle    = 1'b1;
                        end
                    end
                    MODE_STR:
                    begin
                        esc_next = 1'b0;
                        if (esc_reg && (c == cstok_pkg::CH_QUOTE))
                        begin
                            len_next = cstok_pkg::inc_pos(len_reg);
                        end
                        else if (c == cstok_pkg::CH_QUOTE)
                        begin
                            mode_next  = MODE_IDLE;
                            a_valid    = 1'b1;
                            tok_a.kind = cstok_pkg::KIND_STRING;
                        end
                        else
                        begin
                            len_next = cstok_pkg::inc_pos(len_reg);
                            if (c == cstok_pkg::CH_BSLASH)
                            begin
                                esc_next = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        mode_next = MODE_IDLE;
                        do_idle   = 1'b1;
                    end
                endcase

                // Handling of a character seen between tokens.
                if (do_idle && !cstok_pkg::is_space(c))
                begin
                    if (cstok_pkg::single_kind(c) != cstok_pkg::KIND_NONE)
                    begin
                        b_valid    = 1'b1;
                        tok_b.kind = cstok_pkg::single_kind(c);
                    end
                    else if (cstok_pkg::is_pend_char(c))
                    begin
                        pending_next = c;
                        spos_next    = pos_reg;
                        sline_next   = line_reg;
                        scol_next    = col_inc;
                        mode_next    = MODE_PEND;
                    end
                    else if (c == cstok_pkg::CH_QUOTE)
                    begin
                        spos_next  = pos_reg;
                        sline_next = line_reg;
                        scol_next  = col_inc;
                        len_next   = '0;
                        esc_next   = 1'b0;
                        mode_next  = MODE_STR;
                    end
                    else if (cstok_pkg::is_digit(c))
                    begin
                        spos_next  = pos_reg;
                        sline_next = line_reg;
                        scol_next  = col_inc;
                        len_next   = PW'(1);
                        dot_next   = '0;
                        mode_next  = MODE_NUM;
                    end
                    else
                    begin
                        b_valid    = 1'b1;
                        tok_b.kind = cstok_pkg::KIND_ILLEGAL;
                    end
                end
            end
        end

        // The last result of the step carries the run marker.
        tok_a.last = !b_valid;
    end

    // Hand the results of this step to the queue.
    always_comb
    begin
        push.count  = fire ? {a_valid && b_valid, a_valid ^ b_valid} : 2'd0;
        push.first  = a_valid ? tok_a : tok_b;
        push.second = tok_b;
    end

    // State advances only when the step is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_IDLE;
            pending_reg <= '0;
            esc_reg     <= 1'b0;
            cr_reg      <= 1'b0;
            dot_reg     <= '0;
            pos_reg     <= '0;
            line_reg    <= LW'(1);
            col_reg     <= '0;
            spos_reg    <= '0;
            sline_reg   <= LW'(1);
            scol_reg    <= '0;
            len_reg     <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            esc_reg     <= esc_next;
            cr_reg      <= cr_next;
            dot_reg     <= dot_next;
            pos_reg     <= pos_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            spos_reg    <= spos_next;
            sline_reg   <= sline_next;
            scol_reg    <= scol_next;
            len_reg     <= len_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/cstok_queue.sv =====
// Small result queue that takes up to two tokens a cycle and sends one while the receiver is ready.
// Depends on cstok_pkg and the cstok_out_if interface.
`default_nettype none

module cstok_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  cstok_pkg::push_t push,
    output logic             room,
    cstok_out_if.source      token_out
);

    localparam int QW = cstok_pkg::QPTR_W;

    cstok_pkg::token_t entry_reg [cstok_pkg::QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW:0]   count_reg,  count_next;
    logic          pop;
    cstok_pkg::token_t head;

    assign pop  = token_out.valid && token_out.ready;
    assign room = count_reg <= (QW+1)'(cstok_pkg::QUEUE_DEPTH - 2);

    // Pointer and fill bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QW'(push.count);
        rd_ptr_next = rd_ptr_reg + QW'(pop);
        count_next  = count_reg + (QW+1)'(push.count) - (QW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage; payload needs no reset.
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_reg + QW'(1)] <= push.second;
        end
    end

    // Head of the queue drives the result channel.
    assign head = entry_reg[rd_ptr_reg];

    assign token_out.valid          = count_reg != '0;
    assign token_out.token_class    = head.kind;
    assign token_out.start_position = head.position;
    assign token_out.start_line     = head.line;
    assign token_out.start_column   = head.column;
    assign token_out.literal_length = head.length;
    assign token_out.last_of_run    = head.last;

endmodule

`default_nettype wire

// ===== rtl/char_stream_tokenizer_unit.sv =====
// Top level of the character stream tokenizer.
// Depends on cstok_pkg, the channel interfaces, cstok_scan and cstok_queue.
//
// Usage:
//   char_in carries one request per source byte (op = 0, char_code = byte)
//   and a request with op = 1 at end of input. token_out carries tokens:
//   kind, start location, literal length and last_of_run, which marks the
//   final token caused by one request. A request may cause zero, one or
//   two tokens; end of input always yields a closing EOF token.
//   A request waits in the input register until its lexing step is taken;
//   its tokens are then written into the result queue, and a second token
//   leaves the queue after the first.
//   Throughput: one request per cycle while each request gives at most one
//   token and the receiver is ready; the single result port sets the rate to
//   one token per cycle when requests give two.
//   The request path is an input register, combinational lexing logic and a
//   four-entry result queue; requests are taken while the queue holds at most
//   two tokens, so a stalled receiver backs up into char_in.ready after that.
//   Reset empties the queue and returns all counters to line 1, column 0,
//   position 0, between tokens.
`default_nettype none

module char_stream_tokenizer_unit (
    input  logic        clk,
    input  logic        rst_n,
    cstok_in_if.sink    char_in,
    cstok_out_if.source token_out
);

    cstok_pkg::push_t push;
    logic             room;

    // Lexing step with its input register.
    cstok_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_in (char_in),
        .room    (room),
        .push    (push)
    );

    // Result queue, whose head drives the result channel.
    cstok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .token_out (token_out)
    );

endmodule

`default_nettype wire

// ===== rtl/cstok_checker.sv =====
// Port-level checks on the token channel of the tokenizer, bound to the top.
// Depends on cstok_pkg for the token kinds and widths.
`default_nettype none

module cstok_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             valid,
    input logic                             ready,
    input logic [4:0]                       token_class,
    input logic [cstok_pkg::POS_WIDTH-1:0]  start_position,
    input logic [cstok_pkg::LINE_WIDTH-1:0] start_line,
    input logic [cstok_pkg::LINE_WIDTH-1:0] start_column,
    input logic                             last_of_run
);

    // A stalled token stays offered.
    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid)
        else $error("token dropped while stalled");

    // A stalled token keeps its kind and location.
    a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=>
            $stable(token_class) && $stable(start_position)
            && $stable(start_line) && $stable(start_column))
        else $error("token changed while stalled");

    // End of input always closes its run.
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid && (token_class == cstok_pkg::KIND_EOF) |-> last_of_run)
        else $error("EOF token not marked last of run");

    // Lines count from one and saturate, so zero never shows.
    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (start_line != '0))
        else $error("token reported on line zero");

endmodule

bind char_stream_tokenizer_unit cstok_checker u_cstok_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .valid          (token_out.valid),
    .ready          (token_out.ready),
    .token_class    (token_out.token_class),
    .start_position (token_out.start_position),
    .start_line     (token_out.start_line),
    .start_column   (token_out.start_column),
    .last_of_run    (token_out.last_of_run)
);

`default_nettype wire

// ===== bench/char_stream_tokenizer_unit_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for char_stream_tokenizer_unit: directed and random
// streams checked against a built-in lexer prediction.
// Depends on cstok_pkg, the channel interfaces and the tokenizer RTL.

module char_stream_tokenizer_unit_tb;

    localparam int PW = cstok_pkg::POS_WIDTH;
    localparam int LW = cstok_pkg::LINE_WIDTH;

    // Predictor modes.
    localparam logic [1:0] LEX_IDLE    = 2'd0;
    localparam logic [1:0] LEX_PENDING = 2'd1;
    localparam logic [1:0] LEX_NUMBER  = 2'd2;
    localparam logic [1:0] LEX_STRING  = 2'd3;

    logic clk = 1'b0;
    logic rst_n;

    cstok_in_if  char_bus ();
    cstok_out_if token_bus ();

    char_stream_tokenizer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .char_in   (char_bus),
        .token_out (token_bus)
    );

    always #6 clk = ~clk;

    // Lexer state as the testbench sees it.
    logic [1:0]    lex_mode;
    logic [7:0]    held_char;
    logic          after_bslash;
    logic          after_cr;
    int unsigned   dot_seen;
    logic [PW-1:0] pos_ctr;
    logic [LW-1:0] line_ctr;
    logic [LW-1:0] col_ctr;
    logic [PW-1:0] tok_pos;
    logic [LW-1:0] tok_line;
    logic [LW-1:0] tok_col;
    logic [PW-1:0] tok_len;

    // Tokens predicted but not yet seen on the output.
    cstok_pkg::token_t predicted_tokens[$];

    int unsigned send_idle_pct     = 0;
    int unsigned recv_stall_pct    = 0;
    int unsigned error_count       = 0;
    int unsigned requests_accepted = 0;
    int unsigned tokens_checked    = 0;

    function automatic logic [PW-1:0] bump_pos(input logic [PW-1:0] v);
        return (v == {PW{1'b1}}) ? v : v + PW'(1);
    endfunction

    function automatic logic [LW-1:0] bump_line(input logic [LW-1:0] v);
        return (v == {LW{1'b1}}) ? v : v + LW'(1);
    endfunction

    function automatic logic is_num_digit(input logic [7:0] ch);
        return (ch >= cstok_pkg::CH_ZERO) && (ch <= cstok_pkg::CH_NINE);
    endfunction

    // Punctuation that never waits for a second character.
    function automatic logic [4:0] punct_kind(input logic [7:0] ch);
        case (ch)
            "+":               return cstok_pkg::KIND_PLUS;
            "-":               return cstok_pkg::KIND_MINUS;
            "*":               return cstok_pkg::KIND_ASTERISK;
            "/":               return cstok_pkg::KIND_SLASH;
            "(":               return cstok_pkg::KIND_LPAREN;
            ")":               return cstok_pkg::KIND_RPAREN;
            "{":               return cstok_pkg::KIND_LBRACE;
            "}":               return cstok_pkg::KIND_RBRACE;
            "[":               return cstok_pkg::KIND_LBRACKET;
            "]":               return cstok_pkg::KIND_RBRACKET;
            ";":               return cstok_pkg::KIND_SEMICOLON;
            ":":               return cstok_pkg::KIND_COLON;
            ",":               return cstok_pkg::KIND_COMMA;
            cstok_pkg::CH_DOT: return cstok_pkg::KIND_PERIOD;
            default:           return cstok_pkg::KIND_NONE;
        endcase
    endfunction

    // A held operator character that found no partner.
    function automatic logic [4:0] lone_op_kind(input logic [7:0] ch);
        if (ch == cstok_pkg::CH_EQ) return cstok_pkg::KIND_ASSIGN;
        if (ch == cstok_pkg::CH_BANG) return cstok_pkg::KIND_BANG;
        if (ch == cstok_pkg::CH_LT) return cstok_pkg::KIND_LT;
        if (ch == cstok_pkg::CH_GT) return cstok_pkg::KIND_GT;
        return cstok_pkg::KIND_ILLEGAL;
    endfunction

    // Two-character operator formed by a held character and the next one.
    function automatic logic [4:0] pair_op_kind(input logic [7:0] first,
                                                input logic [7:0] ch);
        if (first == cstok_pkg::CH_PIPE)
            return (ch == cstok_pkg::CH_PIPE) ? cstok_pkg::KIND_LOR : cstok_pkg::KIND_NONE;
        if (first == cstok_pkg::CH_AMP)
            return (ch == cstok_pkg::CH_AMP) ? cstok_pkg::KIND_LAND : cstok_pkg::KIND_NONE;
        if (ch != cstok_pkg::CH_EQ) return cstok_pkg::KIND_NONE;
        if (first == cstok_pkg::CH_EQ) return cstok_pkg::KIND_EQ;
        if (first == cstok_pkg::CH_BANG) return cstok_pkg::KIND_NEQ;
        if (first == cstok_pkg::CH_LT) return cstok_pkg::KIND_LTE;
        if (first == cstok_pkg::CH_GT) return cstok_pkg::KIND_GTE;
        return cstok_pkg::KIND_NONE;
    endfunction

    function automatic logic [4:0] number_token_kind(input int unsigned dots);
        if (dots == 0) return cstok_pkg::KIND_INT;
        if (dots == 1) return cstok_pkg::KIND_FLOAT;
        return cstok_pkg::KIND_ILLEGAL;
    endfunction

    task automatic lexer_reset();
        lex_mode     = LEX_IDLE;
        held_char    = '0;
        after_bslash = 1'b0;
        after_cr     = 1'b0;
        dot_seen     = 0;
        pos_ctr      = '0;
        line_ctr     = LW'(1);
        col_ctr      = '0;
        tok_pos      = '0;
        tok_line     = LW'(1);
        tok_col      = '0;
        tok_len      = '0;
    endtask

    task automatic push_token(input logic [4:0] kind, input logic [PW-1:0] p,
                              input logic [LW-1:0] l, input logic [LW-1:0] c,
                              input logic [PW-1:0] len);
        cstok_pkg::token_t tok;
        tok.kind     = kind;
        tok.position = p;
        tok.line     = l;
        tok.column   = c;
        tok.length   = len;
        tok.last     = 1'b0;
        predicted_tokens.push_back(tok);
    endtask

    // A character met between tokens: skip, emit at once, or open a token.
    task automatic lex_from_idle(input logic [7:0] ch, input logic [PW-1:0] p,
                                 input logic [LW-1:0] l, input logic [LW-1:0] c);
        logic [4:0] k;
        k = punct_kind(ch);
        if (ch inside {cstok_pkg::CH_SPACE, cstok_pkg::CH_TAB, cstok_pkg::CH_LF,
                       cstok_pkg::CH_CR})
        begin
            // Whitespace only moves the counters.
        end
        else if (k != cstok_pkg::KIND_NONE)
        begin
            push_token(k, p, l, c, PW'(1));
        end
        else if (ch inside {cstok_pkg::CH_BANG, cstok_pkg::CH_EQ, cstok_pkg::CH_LT,
                            cstok_pkg::CH_GT, cstok_pkg::CH_PIPE, cstok_pkg::CH_AMP})
        begin
            held_char = ch;
            tok_pos   = p;
            tok_line  = l;
            tok_col   = c;
            lex_mode  = LEX_PENDING;
        end
        else if (ch == cstok_pkg::CH_QUOTE)
        begin
            tok_pos      = p;
            tok_line     = l;
            tok_col      = c;
            tok_len      = '0;
            after_bslash = 1'b0;
            lex_mode     = LEX_STRING;
        end
        else if (is_num_digit(ch))
        begin
            tok_pos  = p;
            tok_line = l;
            tok_col  = c;
            tok_len  = PW'(1);
            dot_seen = 0;
            lex_mode = LEX_NUMBER;
        end
        else
        begin
            push_token(cstok_pkg::KIND_ILLEGAL, p, l, c, PW'(1));
        end
    endtask

    // Predict the tokens caused by one accepted request.
    task automatic lex_request(input logic op, input logic [7:0] ch);
        int unsigned       first_new;
        logic [PW-1:0]     p;
        logic [LW-1:0]     l;
        logic [LW-1:0]     c;
        logic [4:0]        k;
        cstok_pkg::token_t tail;
        first_new = predicted_tokens.size();
        if (op == cstok_pkg::OP_END)
        begin
            // Flush the open token, then EOF at the current location.
            case (lex_mode)
                LEX_PENDING:
                begin
                    push_token(lone_op_kind(held_char), tok_pos, tok_line, tok_col, PW'(1));
                end
                LEX_NUMBER:
                begin
                    push_token(number_token_kind(dot_seen), tok_pos, tok_line, tok_col,
                               tok_len);
                end
                LEX_STRING:
                begin
                    push_token(cstok_pkg::KIND_STRING, tok_pos, tok_line, tok_col, tok_len);
                end
                default:
                begin
                end
            endcase
            push_token(cstok_pkg::KIND_EOF, pos_ctr, line_ctr, col_ctr, '0);
            lexer_reset();
        end
        else
        begin
            p = pos_ctr;
            pos_ctr = bump_pos(pos_ctr);
            if (after_cr && (ch == cstok_pkg::CH_LF))
            begin
                // The LF of a CR LF pair is no character of its own.
                after_cr = 1'b0;
                if (lex_mode == LEX_STRING)
                begin
                    tok_len = bump_pos(tok_len);
                end
            end
            else
            begin
                col_ctr = bump_line(col_ctr);
                l = line_ctr;
                c = col_ctr;
                if ((ch == cstok_pkg::CH_LF) || (ch == cstok_pkg::CH_CR))
                begin
                    line_ctr = bump_line(line_ctr);
                    col_ctr  = '0;
                end
                after_cr = (ch == cstok_pkg::CH_CR);
                case (lex_mode)
                    LEX_PENDING:
                    begin
                        k = pair_op_kind(held_char, ch);
                        lex_mode = LEX_IDLE;
                        if (k != cstok_pkg::KIND_NONE)
                        begin
                            tok_len = PW'(2);
                            push_token(k, tok_pos, tok_line, tok_col, tok_len);
                        end
                        else
                        begin
                            tok_len = PW'(1);
                            push_token(lone_op_kind(held_char), tok_pos, tok_line, tok_col,
                                       tok_len);
                            lex_from_idle(ch, p, l, c);
                        end
                    end
                    LEX_NUMBER:
                    begin
                        if (is_num_digit(ch) || (ch == cstok_pkg::CH_DOT))
                        begin
                            tok_len = bump_pos(tok_len);
                            if ((ch == cstok_pkg::CH_DOT) && (dot_seen < 2))
                            begin
                                dot_seen++;
                            end
                        end
                        else
                        begin
                            lex_mode = LEX_IDLE;
                            push_token(number_token_kind(dot_seen), tok_pos, tok_line,
                                       tok_col, tok_len);
                            lex_from_idle(ch, p, l, c);
                        end
                    end
                    LEX_STRING:
                    begin
                        if (after_bslash && (ch == cstok_pkg::CH_QUOTE))
                        begin
                            after_bslash = 1'b0;
                            tok_len = bump_pos(tok_len);
                        end
                        else
                        begin
                            after_bslash = 1'b0;
                            if (ch == cstok_pkg::CH_QUOTE)
                            begin
                                lex_mode = LEX_IDLE;
                                push_token(cstok_pkg::KIND_STRING, tok_pos, tok_line,
                                           tok_col, tok_len);
                            end
                            else
                            begin
                                tok_len = bump_pos(tok_len);
                                if (ch == cstok_pkg::CH_BSLASH)
                                begin
                                    after_bslash = 1'b1;
                                end
                            end
                        end
                    end
                    default:
                    begin
                        lex_from_idle(ch, p, l, c);
                    end
                endcase
            end
        end
        // Mark the final token of this request.
        if (predicted_tokens.size() > first_new)
        begin
            tail = predicted_tokens.pop_back();
            tail.last = 1'b1;
            predicted_tokens.push_back(tail);
        end
    endtask

    // Send one request; called at a rising edge, returns at the accepting edge.
    // Valid stays high on return so that back-to-back requests need no toggle.
    task automatic send_request(input logic op, input logic [7:0] ch);
        logic took;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            char_bus.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        char_bus.valid     <= 1'b1;
        char_bus.op        <= op;
        char_bus.char_code <= ch;
        // Ready is sampled between edges, where it has settled.
        do
        begin
            @(negedge clk);
            took = char_bus.ready;
            @(posedge clk);
        end
        while (!took);
        lex_request(op, ch);
        requests_accepted++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            send_request(cstok_pkg::OP_CHAR, s[i]);
        end
    endtask

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got)
        begin
            error_count++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, field, want, got);
        end
    endtask

    // Result side: check each accepted token and stall at random.
    initial
    begin : token_checker
        cstok_pkg::token_t want;
        token_bus.ready <= 1'b0;
        forever
        begin
            // The channel is sampled between edges, where it has settled.
            @(negedge clk);
            if (rst_n && token_bus.valid && token_bus.ready)
            begin
                if (predicted_tokens.size() == 0)
                begin
                    error_count++;
                    $display("%0t ns: unexpected token, expected none, actual kind %0d",
                             $time, token_bus.token_class);
                end
                else
                begin
                    want = predicted_tokens.pop_front();
                    compare_field("token_class", 32'(want.kind),
                                  32'(token_bus.token_class));
                    compare_field("start_position", 32'(want.position),
                                  32'(token_bus.start_position));
                    compare_field("start_line", 32'(want.line), 32'(token_bus.start_line));
                    compare_field("start_column", 32'(want.column),
                                  32'(token_bus.start_column));
                    compare_field("literal_length", 32'(want.length),
                                  32'(token_bus.literal_length));
                    compare_field("last_of_run", 32'(want.last), 32'(token_bus.last_of_run));
                    tokens_checked++;
                end
            end
            @(posedge clk);
            token_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Operators, pairs, numbers, line breaks, escapes, byte extremes and
    // every way a token can be cut off by end of input.
    task automatic test_directed_tokens();
        send_text("==!x1.5.");
        send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_CR);
        send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_LF);
        send_text("\"\\\"\\q");
        send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_LF);
        send_text("\"");
        send_request(cstok_pkg::OP_CHAR, 8'h00);
        send_request(cstok_pkg::OP_CHAR, 8'hFF);
        send_text("<||\"\\");
        send_request(cstok_pkg::OP_END, 8'h00);
        send_text("&");
        send_request(cstok_pkg::OP_END, 8'hFF);
        send_text("7.");
        send_request(cstok_pkg::OP_END, 8'h00);
    endtask

    // One short piece of source text, mostly well formed.
    task automatic send_random_fragment();
        string       puncts;
        string       pendings;
        string       partners;
        int unsigned pick;
        int unsigned n;
        logic [7:0]  ch;
        puncts   = "+-*/(){}[];:,.";
        pendings = "=!<>|&";
        partners = "=|&";
        pick = $urandom_range(0, 99);
        if (pick < 16)
        begin
            send_request(cstok_pkg::OP_CHAR, puncts[$urandom_range(0, puncts.len() - 1)]);
        end
        else if (pick < 34)
        begin
            send_request(cstok_pkg::OP_CHAR, pendings[$urandom_range(0, pendings.len() - 1)]);
            if ($urandom_range(0, 99) < 60)
            begin
                send_request(cstok_pkg::OP_CHAR,
                             partners[$urandom_range(0, partners.len() - 1)]);
            end
        end
        else if (pick < 52)
        begin
            n = $urandom_range(1, 6);
            send_request(cstok_pkg::OP_CHAR, 8'(cstok_pkg::CH_ZERO + $urandom_range(0, 9)));
            for (int i = 1; i < n; i++)
            begin
                if ($urandom_range(0, 99) < 20)
                begin
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_DOT);
                end
                else
                begin
                    send_request(cstok_pkg::OP_CHAR,
                                 8'(cstok_pkg::CH_ZERO + $urandom_range(0, 9)));
                end
            end
        end
        else if (pick < 68)
        begin
            n = $urandom_range(0, 8);
            send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_QUOTE);
            for (int i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 15)
                begin
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_BSLASH);
                end
                else if (pick < 25)
                begin
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_BSLASH);
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_QUOTE);
                end
                else if (pick < 35)
                begin
                    send_request(cstok_pkg::OP_CHAR, ($urandom_range(0, 1) != 0) ?
                                 cstok_pkg::CH_CR : cstok_pkg::CH_LF);
                end
                else
                begin
                    ch = 8'($urandom_range(0, 255));
                    send_request(cstok_pkg::OP_CHAR, ch);
                end
            end
            if ($urandom_range(0, 99) < 90)
            begin
                send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_QUOTE);
            end
        end
        else if (pick < 82)
        begin
            case ($urandom_range(0, 4))
                0:
                begin
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_SPACE);
                end
                1:
                begin
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_TAB);
                end
                2:
                begin
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_LF);
                end
                3:
                begin
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_CR);
                end
                default:
                begin
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_CR);
                    send_request(cstok_pkg::OP_CHAR, cstok_pkg::CH_LF);
                end
            endcase
        end
        else if (pick < 96)
        begin
            send_request(cstok_pkg::OP_CHAR, 8'($urandom_range(0, 255)));
        end
        else
        begin
            send_request(cstok_pkg::OP_END, 8'($urandom_range(0, 255)));
        end
    endtask

    task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                      input int unsigned count);
        int unsigned target;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        target = requests_accepted + count;
        while (requests_accepted < target)
        begin
            send_random_fragment();
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        char_bus.valid     <= 1'b0;
        char_bus.op        <= cstok_pkg::OP_CHAR;
        char_bus.char_code <= '0;
        lexer_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct  = 7;
        recv_stall_pct = 68;
        test_directed_tokens();
        test_random_stream(7, 68, 540);
        test_random_stream(68, 7, 540);
        test_random_stream(0, 0, 540);

        // Let every predicted token drain, then watch for strays.
        char_bus.valid <= 1'b0;
        while (predicted_tokens.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("Checked %0d tokens from %0d requests: directed cases and random streams",
                 tokens_checked, requests_accepted);
        $display("with sender stalls, with receiver stalls and with no stalls at all.");
        if (error_count == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d tokens still predicted.", predicted_tokens.size());
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/cstok_pkg.sv
rtl/cstok_ifs.sv
rtl/cstok_scan.sv
rtl/cstok_queue.sv
rtl/char_stream_tokenizer_unit.sv
rtl/cstok_checker.sv
bench/char_stream_tokenizer_unit_tb.sv
